/* rtl/core/rmq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Range-minimum engine package
// Shared sizes, operation and status codes, the queue entry and small helpers.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int DATA_W       = 32;
  localparam int MAX_ELEMENTS = 4096;
  localparam int BLOCK_SIZE   = 32;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int POS_W        = $clog2(BLOCK_SIZE);
  localparam int NUM_BLOCKS   = MAX_ELEMENTS / BLOCK_SIZE;
  localparam int BLK_W        = $clog2(NUM_BLOCKS);
  localparam int LEVELS       = BLK_W + 1;
  localparam int LVL_W        = $clog2(LEVELS);
  localparam int SP_AW        = LVL_W + BLK_W;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_BAD_RANGE = 2'd2
  } status_t;

  // What the back end has to do with an entry.
  typedef enum logic [1:0] {
    KIND_RESULT = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                     kind;
    status_t                   status;
    logic signed [DATA_W-1:0]  value;
    logic [IDX_W-1:0]          left;
    logic [IDX_W-1:0]          right;
    logic [IDX_W-1:0]          index;
  } cmd_t;

  // Index of the highest set bit, zero for an empty mask.
  function automatic logic [POS_W-1:0] high_bit(input logic [BLOCK_SIZE-1:0] x);
    logic [POS_W-1:0] n;
    n = '0;
    for (int i = 0; i < BLOCK_SIZE; i++) begin
      if (x[i]) begin
        n = POS_W'(i);
      end
    end
    return n;
  endfunction

  function automatic logic signed [DATA_W-1:0] smin(input logic signed [DATA_W-1:0] a,
                                                    input logic signed [DATA_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/rmq_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Command queue
// Small register queue between the front end and the back end.
// ----------------------------------------------------------------------------
module rmq_fifo
  import rmq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  rmq_pkg::cmd_t    push_data,
  input  wire logic        pop,
  output rmq_pkg::cmd_t    head,
  output logic             full,
  output logic             empty
);

  cmd_t                 slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wptr;
  logic [FIFO_AW-1:0]   rptr;
  logic [FIFO_AW:0]     fill;

  assign full  = (fill == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (!push && pop) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/rmq_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Front end
// Accepts transactions, tracks the element count and classifies each one.
// ----------------------------------------------------------------------------
module rmq_front
  import rmq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         operation,
  input  wire logic [31:0]        value,
  input  wire logic [11:0]        left,
  input  wire logic [11:0]        right,
  input  wire logic               q_full,
  output logic                    push,
  output rmq_pkg::cmd_t           push_data
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_data        = '0;
    push_data.value  = value;
    push_data.left   = left;
    push_data.right  = right;
    push_data.index  = count[IDX_W-1:0];
    push_data.kind   = KIND_RESULT;
    push_data.status = STATUS_OK;
    count_next       = count;
    unique case (op_t'(operation))
      OP_APPEND: begin
        if (count >= CNT_W'(MAX_ELEMENTS)) begin
          push_data.status = STATUS_FULL;
        end else begin
          push_data.kind = KIND_APPEND;
          count_next     = count + 1'b1;
        end
      end
      OP_QUERY: begin
        if (left > right || {1'b0, right} >= count) begin
          push_data.status = STATUS_BAD_RANGE;
        end else begin
          push_data.kind = KIND_QUERY;
        end
      end
      OP_CLEAR: begin
        push_data.kind = KIND_CLEAR;
        count_next     = '0;
      end
      default: begin
        push_data.kind = KIND_RESULT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push) begin
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/rmq_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Back end
// Sequencer that owns the stores, performs appends, sparse-table updates and
// queries, and holds the result register.
// ----------------------------------------------------------------------------
module rmq_back
  import rmq_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  rmq_pkg::cmd_t       head,
  input  wire logic           q_empty,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [31:0]         minimum,
  output logic [1:0]          status
);

  typedef enum logic [3:0] {
    S_IDLE, S_APP1, S_APP2, S_SP_RD, S_SP_WR,
    S_Q1, S_Q2, S_Q3S, S_Q3L, S_Q4L, S_Q5L, S_DONE
  } state_t;

  state_t                     state;
  cmd_t                       cmd;
  logic [BLOCK_SIZE-1:0]      rmask;
  logic [BLOCK_SIZE-1:0]      lt;
  logic signed [DATA_W-1:0]   win [1:BLOCK_SIZE-1];
  logic signed [DATA_W-1:0]   bmin;
  logic signed [DATA_W-1:0]   acc;
  logic signed [DATA_W-1:0]   res_min;
  status_t                    res_status;
  logic [LVL_W:0]             d;

  logic signed [DATA_W-1:0]   elem_mem  [MAX_ELEMENTS];
  logic [BLOCK_SIZE-1:0]      smask_mem [MAX_ELEMENTS];
  logic signed [DATA_W-1:0]   wmin_mem  [MAX_ELEMENTS];
  logic signed [DATA_W-1:0]   sp_mem    [LEVELS*NUM_BLOCKS];

  logic signed [DATA_W-1:0]   elem_rd, wmin_rd, sp_rd;
  logic [BLOCK_SIZE-1:0]      smask_rd;
  logic [IDX_W-1:0]           elem_ra, wmin_ra;
  logic [SP_AW-1:0]           sp_ra, sp_wa;
  logic                       sp_we;
  logic signed [DATA_W-1:0]   sp_wd;

  // Append datapath.
  logic [BLOCK_SIZE-1:0]      m_new;
  logic [POS_W-1:0]           m_top;
  logic signed [DATA_W-1:0]   wm_new;
  logic signed [DATA_W-1:0]   bmin_new;
  logic [POS_W-1:0]           pos;
  logic [BLK_W-1:0]           blk;
  logic [BLK_W:0]             kp1, pow;
  logic [BLK_W-1:0]           jd;
  logic                       lvl_go;
  logic signed [DATA_W-1:0]   cur_new;

  // Query datapath.
  logic [IDX_W:0]             len;
  logic                       is_short;
  logic [BLOCK_SIZE-1:0]      sel;
  logic [IDX_W-1:0]           lw;
  logic [BLK_W-1:0]           lb, rhi;
  logic                       has_sp;
  logic [LVL_W-1:0]           qd;
  logic signed [DATA_W-1:0]   acc2;

  always_comb begin
    m_new    = ({rmask[BLOCK_SIZE-2:0], 1'b0} & ~lt) | BLOCK_SIZE'(1);
    m_top    = high_bit(m_new);
    wm_new   = (m_top == '0) ? cmd.value : win[m_top];
    pos      = cmd.index[POS_W-1:0];
    blk      = cmd.index[IDX_W-1:POS_W];
    bmin_new = (pos == '0) ? cmd.value : smin(bmin, cmd.value);
    kp1      = {1'b0, blk} + 1'b1;
    pow      = (BLK_W+1)'(1) << d;
    jd       = BLK_W'(kp1 - pow);
    lvl_go   = (d < (LVL_W+1)'(LEVELS)) && (pow <= kp1);
    cur_new  = smin(sp_rd, bmin);

    len      = {1'b0, cmd.right} - {1'b0, cmd.left} + 1'b1;
    is_short = len < (IDX_W+1)'(BLOCK_SIZE);
    sel      = smask_rd & ~({BLOCK_SIZE{1'b1}} << len[POS_W-1:0]);
    lw       = cmd.left + IDX_W'(BLOCK_SIZE - 1);
    lb       = lw[IDX_W-1:POS_W];
    rhi      = cmd.right[IDX_W-1:POS_W];
    has_sp   = lb < rhi;
    qd       = LVL_W'(high_bit(BLOCK_SIZE'(rhi - lb)));
    acc2     = smin(acc, wmin_rd);
  end

  // Read addresses and sparse-table write port.
  always_comb begin
    elem_ra = cmd.right - IDX_W'(high_bit(sel));
    wmin_ra = (state == S_Q2) ? lw : cmd.right;
    sp_ra   = {d[LVL_W-1:0] - 1'b1, jd};
    if (state == S_Q3L) begin
      sp_ra = {qd, lb};
    end else if (state == S_Q4L) begin
      sp_ra = {qd, BLK_W'(rhi - (BLK_W'(1) << qd))};
    end
    sp_we = 1'b0;
    sp_wa = {LVL_W'(0), blk};
    sp_wd = bmin_new;
    if (state == S_APP2 && pos == POS_W'(BLOCK_SIZE - 1)) begin
      sp_we = 1'b1;
    end else if (state == S_SP_WR) begin
      sp_we = 1'b1;
      sp_wa = {d[LVL_W-1:0], jd};
      sp_wd = cur_new;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_APP2) begin
      elem_mem[cmd.index]  <= cmd.value;
      smask_mem[cmd.index] <= m_new;
      wmin_mem[cmd.index]  <= wm_new;
    end
    if (sp_we) begin
      sp_mem[sp_wa] <= sp_wd;
    end
    elem_rd  <= elem_mem[elem_ra];
    smask_rd <= smask_mem[cmd.right];
    wmin_rd  <= wmin_mem[wmin_ra];
    sp_rd    <= sp_mem[sp_ra];
  end

  // Shift line of the most recent elements; win[t] is the element t places back.
  always_ff @(posedge clk) begin
    if (state == S_APP2) begin
      win[1] <= cmd.value;
      for (int t = 2; t < BLOCK_SIZE; t++) begin
        win[t] <= win[t-1];
      end
    end
  end

  assign pop = (state == S_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rmask     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cmd        <= head;
            res_min    <= '0;
            res_status <= head.status;
            unique case (head.kind)
              KIND_APPEND: state <= S_APP1;
              KIND_QUERY:  state <= S_Q1;
              KIND_CLEAR: begin
                rmask <= '0;
                state <= S_DONE;
              end
              default:     state <= S_DONE;
            endcase
          end
        end
        S_APP1: begin
          lt[0] <= 1'b0;
          for (int t = 1; t < BLOCK_SIZE; t++) begin
            lt[t] <= cmd.value < win[t];
          end
          state <= S_APP2;
        end
        S_APP2: begin
          rmask <= m_new;
          bmin  <= bmin_new;
          d     <= (LVL_W+1)'(1);
          state <= (pos == POS_W'(BLOCK_SIZE - 1)) ? S_SP_RD : S_DONE;
        end
        S_SP_RD: begin
          state <= lvl_go ? S_SP_WR : S_DONE;
        end
        S_SP_WR: begin
          bmin  <= cur_new;
          d     <= d + 1'b1;
          state <= S_SP_RD;
        end
        S_Q1: begin
          state <= S_Q2;
        end
        S_Q2: begin
          acc   <= wmin_rd;
          state <= is_short ? S_Q3S : S_Q3L;
        end
        S_Q3S: begin
          res_min <= elem_rd;
          state   <= S_DONE;
        end
        S_Q3L: begin
          acc     <= acc2;
          res_min <= acc2;
          state   <= has_sp ? S_Q4L : S_DONE;
        end
        S_Q4L: begin
          acc   <= smin(acc, sp_rd);
          state <= S_Q5L;
        end
        S_Q5L: begin
          res_min <= smin(acc, sp_rd);
          state   <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            minimum   <= res_min;
            status    <= res_status;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/core/range_minimum_query_engine_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Clears, rejected and unused codes go straight to the result state; an append passes
// through S_APP1 and S_APP2, a query through S_Q1, S_Q2 and S_Q3S or S_Q3L, and a long
// query that reads the sparse table also through S_Q4L and S_Q5L. An append that closes a
// block of 32 then builds up to 7 sparse-table levels, each with a store read and a write.
// The back end takes one transaction at a time; a 4-entry queue lets the input side run
// ahead. Reset clears the count, stack mask, queue, sequencer state and out_valid only.
// ----------------------------------------------------------------------------
// Range-minimum query engine
// Appends signed elements, answers range-minimum queries over them, and clears on request.
// ----------------------------------------------------------------------------
module range_minimum_query_engine_unit
  import rmq_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [1:0]   operation,
  input  wire logic [31:0]  value,
  input  wire logic [11:0]  left,
  input  wire logic [11:0]  right,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [31:0]       minimum,
  output logic [1:0]        status
);

  // The front end checks each transaction against its own element count, so
  // bad ranges and appends to a full store are settled before the queue. The
  // back end then only sees work that it can carry out without further checks.
  cmd_t push_data;
  cmd_t head;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  rmq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .value     (value),
    .left      (left),
    .right     (right),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // The queue decouples acceptance from the multi-cycle back-end work.
  rmq_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // The back end keeps the stores, the monotone stack mask and the sparse table.
  rmq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .minimum   (minimum),
    .status    (status)
  );

  // A result that carries an error status must report a zero minimum.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_OK |-> minimum == '0)
    else $error("error result with nonzero minimum");

  // The queue is never written while full.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("queue overflow");

  // The back end never takes an entry from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty)
    else $error("queue underflow");

endmodule
`default_nettype wire

/* tb/rmq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range-minimum engine checker
// Watches both channels, keeps its own copy of the element store, the stack
// masks and the block sparse table, and compares each result in order.
// ----------------------------------------------------------------------------
module rmq_checker
  import rmq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [31:0] value,
  input  logic [11:0] left,
  input  logic [11:0] right,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] minimum,
  input  logic [1:0]  status,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [31:0] minimum;
    status_t     status;
  } answer_t;

  logic signed [31:0] elem_q [MAX_ELEMENTS];
  logic [31:0]        mask_q [MAX_ELEMENTS];
  logic signed [31:0] wmin_q [MAX_ELEMENTS];
  logic signed [31:0] blk_q  [NUM_BLOCKS];
  logic signed [31:0] sparse_q [1:7][NUM_BLOCKS];
  logic [31:0]        live_mask;
  int                 loaded;
  answer_t            answers_due [$];

  function automatic int top_bit(input logic [31:0] x);
    int n;
    n = 0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) begin
        n = i;
      end
    end
    return n;
  endfunction

  function automatic logic signed [31:0] lesser(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [31:0] level_at(input int d, input int j);
    if (j >= NUM_BLOCKS) begin
      return '0;
    end
    if (d == 0) begin
      return blk_q[j];
    end
    return sparse_q[d][j];
  endfunction

  task automatic push_element(input logic signed [31:0] v);
    int          i;
    int          t;
    int          k;
    int          j;
    logic [31:0] m;
    i = loaded;
    m = {live_mask[30:0], 1'b0};
    // Pop every stack entry that is larger than the new element.
    while (m != 0) begin
      t = 0;
      while (!m[t]) t++;
      if (t > i || !(v < elem_q[i - t])) break;
      m[t] = 1'b0;
    end
    m[0] = 1'b1;
    elem_q[i] = v;
    live_mask = m;
    mask_q[i] = m;
    wmin_q[i] = elem_q[i - top_bit(m)];
    if (i % BLOCK_SIZE == 0) begin
      blk_q[i / BLOCK_SIZE] = v;
    end else begin
      blk_q[i / BLOCK_SIZE] = lesser(blk_q[i / BLOCK_SIZE], v);
    end
    if (i % BLOCK_SIZE == BLOCK_SIZE - 1) begin
      k = i / BLOCK_SIZE;
      for (int d = 1; d <= 7 && (1 << d) <= k + 1; d++) begin
        j = k + 1 - (1 << d);
        sparse_q[d][j] = lesser(level_at(d - 1, j), level_at(d - 1, j + (1 << (d - 1))));
      end
    end
    loaded = i + 1;
  endtask

  function automatic logic signed [31:0] range_min(input int l, input int r);
    int                 len;
    int                 lb;
    int                 rb;
    int                 d;
    int                 span;
    logic [31:0]        sel;
    logic signed [31:0] k;
    len = r - l + 1;
    if (len < BLOCK_SIZE) begin
      sel = mask_q[r] & ((32'd1 << len) - 32'd1);
      return elem_q[r - top_bit(sel)];
    end
    k = lesser(wmin_q[r], wmin_q[l + BLOCK_SIZE - 1]);
    lb = (l + BLOCK_SIZE - 1) / BLOCK_SIZE;
    rb = r / BLOCK_SIZE - 1;
    if (rb >= 0 && lb <= rb) begin
      span = rb - lb + 1;
      d = 0;
      while ((span >> (d + 1)) != 0) d++;
      k = lesser(k, lesser(level_at(d, lb), level_at(d, rb + 1 - (1 << d))));
    end
    return k;
  endfunction

  task automatic predict(input logic [1:0] op, input logic [31:0] v,
                         input int l, input int r);
    answer_t a;
    a.minimum = '0;
    a.status  = STATUS_OK;
    case (op_t'(op))
      OP_APPEND: begin
        if (loaded >= MAX_ELEMENTS) a.status = STATUS_FULL;
        else push_element(v);
      end
      OP_QUERY: begin
        if (l > r || r >= loaded) a.status = STATUS_BAD_RANGE;
        else a.minimum = range_min(l, r);
      end
      OP_CLEAR: begin
        loaded = 0;
        live_mask = '0;
      end
      default: ;
    endcase
    answers_due.insert(answers_due.size(), a);
  endtask

  initial begin
    errors = 0;
    loaded = 0;
    live_mask = '0;
  end

  always @(posedge clk) begin
    answer_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result min=%h status=%0d", minimum, status);
        end else begin
          want = answers_due.pop_front();
          if (minimum !== want.minimum || status !== want.status) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: expected min=%h status=%0d, got min=%h status=%0d",
                       want.minimum, want.status, minimum, status);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        predict(operation, value, int'(left), int'(right));
      end
    end
    pending = answers_due.size();
  end

endmodule

/* tb/tb_range_minimum_query_engine_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range-minimum engine testbench
// Drives appends, queries, clears and the unused code with bursty input and a
// stalling output, loads 1024 elements once, and lets the checker compare every result.
// ----------------------------------------------------------------------------
module tb_range_minimum_query_engine_unit;
  import rmq_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  operation = OP_NONE;
  logic [31:0] value = '0;
  logic [11:0] left = '0;
  logic [11:0] right = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] minimum;
  logic [1:0]  status;
  int          errors;
  int          pending;

  // Stimulus-side view of how many elements are loaded, used to aim queries
  // at valid ranges and to end the loading phase.
  int          fill_level = 0;
  int          burst_left = 0;
  int          sent = 0;
  int          ready_phase = 0;
  int          ready_mode = 0;
  int          cyc = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  range_minimum_query_engine_unit dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .value(value), .left(left), .right(right),
    .out_valid(out_valid), .out_ready(out_ready), .minimum(minimum), .status(status)
  );

  rmq_checker u_checker (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .value(value), .left(left), .right(right),
    .out_valid(out_valid), .out_ready(out_ready), .minimum(minimum), .status(status),
    .errors(errors), .pending(pending)
  );

  // The receiver stalls on its own schedule. Each phase picks one of several
  // patterns, including a phase of no stalls at all.
  always @(negedge clk) begin
    cyc++;
    if (rst) begin
      out_ready = 1'b0;
    end else begin
      if (ready_phase == 0) begin
        ready_mode  = $urandom_range(0, 3);
        ready_phase = $urandom_range(10, 200);
      end
      ready_phase--;
      case (ready_mode)
        0: out_ready = 1'b1;
        1: out_ready = $urandom_range(0, 1);
        2: out_ready = ($urandom_range(0, 4) == 0);
        default: out_ready = ((cyc % 7) < 3);
      endcase
    end
  end

  // Presents one transaction at a falling edge and holds it until the rising
  // edge that accepts it. Between most bursts the sender goes quiet for a while.
  task automatic send(input op_t op, input logic [31:0] v,
                      input logic [11:0] l, input logic [11:0] r);
    in_valid  = 1'b1;
    operation = op;
    value     = v;
    left      = l;
    right     = r;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent++;
    if (op == OP_APPEND && fill_level < MAX_ELEMENTS) fill_level++;
    if (op == OP_CLEAR) fill_level = 0;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 16)) - 8);
      2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: return 32'($urandom_range(0, 1000));
    endcase
  endfunction

  // A query mostly inside the loaded range, with short, medium and long spans.
  task automatic send_query();
    int r;
    int l;
    int len;
    if (fill_level == 0 || $urandom_range(0, 15) == 0) begin
      send(OP_QUERY, $urandom, 12'($urandom), 12'($urandom));
    end else begin
      r = $urandom_range(0, fill_level - 1);
      case ($urandom_range(0, 3))
        0: len = $urandom_range(1, 31);
        1: len = $urandom_range(32, 40);
        2: len = $urandom_range(41, 400);
        default: len = $urandom_range(1, r + 1);
      endcase
      l = r - len + 1;
      if (l < 0) l = 0;
      send(OP_QUERY, $urandom, 12'(l), 12'(r));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: empty-store queries, value extremes, the unused code,
    // inverted ranges and a range that runs past the loaded elements.
    send(OP_QUERY, '0, 12'd0, 12'd0);
    send(OP_APPEND, 32'h8000_0000, '0, '0);
    send(OP_APPEND, 32'h7FFF_FFFF, '0, '0);
    send(OP_APPEND, 32'h0000_0000, '0, '0);
    send(OP_APPEND, 32'hFFFF_FFFF, '0, '0);
    send(OP_APPEND, 32'h7FFF_FFFF, '0, '0);
    send(OP_QUERY, '0, 12'd0, 12'd4);
    send(OP_QUERY, '0, 12'd1, 12'd4);
    send(OP_QUERY, '0, 12'd2, 12'd2);
    send(OP_QUERY, '0, 12'd3, 12'd1);
    send(OP_QUERY, '0, 12'd0, 12'd5);
    send(OP_QUERY, '0, 12'd4095, 12'd4095);
    send(OP_NONE, 32'hFFFF_FFFF, 12'hFFF, 12'hFFF);
    send(OP_CLEAR, '0, '0, '0);
    send(OP_QUERY, '0, 12'd0, 12'd0);

    // Load 32 blocks so that several sparse-table levels get built, then probe
    // the full range, the last block, a long inner span and a range past the end.
    while (fill_level < 1024) begin
      send(OP_APPEND, pick_value(), '0, '0);
      if ($urandom_range(0, 40) == 0) send_query();
    end
    send(OP_QUERY, '0, 12'd0, 12'd1023);
    send(OP_QUERY, '0, 12'd992, 12'd1023);
    send(OP_QUERY, '0, 12'd31, 12'd992);
    send(OP_QUERY, '0, 12'd0, 12'd4095);
    repeat (60) send_query();
    send(OP_CLEAR, '0, '0, '0);

    // Random part: mostly appends and in-range queries, with occasional
    // clears, junk queries and the unused code.
    repeat (750) begin
      case ($urandom_range(0, 99))
        0, 1:                 send(OP_CLEAR, $urandom, 12'($urandom), 12'($urandom));
        2:                    send(OP_NONE, $urandom, 12'($urandom), 12'($urandom));
        default: begin
          if ($urandom_range(0, 99) < 55) send(OP_APPEND, pick_value(), 12'($urandom),
                                               12'($urandom));
          else send_query();
        end
      endcase
    end
    in_valid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d transactions: appends across many blocks, queries of all spans,", sent);
    $display("clears, the unused code and invalid ranges, under bursty input and stalls.");
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* range_minimum_query_engine_unit.f */
rtl/core/rmq_pkg.sv
rtl/core/rmq_fifo.sv
rtl/core/rmq_front.sv
rtl/core/rmq_back.sv
rtl/core/range_minimum_query_engine_unit.sv
tb/rmq_checker.sv
tb/tb_range_minimum_query_engine_unit.sv
